// File: rtl/core/pwl_act_pkg.sv
package pwl_act_pkg;

   // Field widths
   localparam int unsigned CSR_W       = 8;
   localparam int unsigned SEG_INDEX_W = 7;
   localparam int unsigned BASE_W      = 32;
   localparam int unsigned BASE_DROP_W = 2;
   localparam int unsigned BASE_KEEP_W = BASE_W - BASE_DROP_W;
   localparam int unsigned SEL_W       = 2;
   localparam int unsigned LEVEL_W     = 16;
   localparam int unsigned SLOPE_W     = 16;
   localparam int unsigned SAMPLE_W    = 32;
   localparam int unsigned OUT_W       = 16;

   // Default table depth
   localparam int unsigned DEF_MAX_SEGMENTS = 128;

   // Action codes
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_EVAL  = 1'b1;

   // Output clamp limits
   localparam int SAT_HI = 32767;
   localparam int SAT_LO = -32768;

   typedef struct packed {
      logic                        action;
      logic [SEG_INDEX_W-1:0]      seg_index;
      logic signed [BASE_W-1:0]    seg_base;
      logic [SEL_W-1:0]            seg_shift_select;
      logic signed [LEVEL_W-1:0]   seg_level;
      logic signed [SLOPE_W-1:0]   seg_slope;
      logic signed [SAMPLE_W-1:0]  sample;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] out_value;
      logic                    saturated;
   } rsp_type;

endpackage

// File: rtl/core/pwl_activation_eval_top.sv
// An accepted evaluate beat passes the entry slot, the search slots, then the lookup,
//   difference, product and output registers before its response beat.
// Throughput: one beat per cycle; a stalled response holds the whole pipeline.
// The search takes one stage per index bit, each stage reading its own copy of the bases.
// Reset (synchronous, active high) clears every valid bit and the segment count; the
//   segment table is undefined until written and is not cleared.
module pwl_activation_eval_top
   import pwl_act_pkg::*;
#(
   parameter int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   // configuration
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   // Index and count widths
   localparam int unsigned AW    = $clog2(MAX_SEGMENTS);
   localparam int unsigned STEPS = AW;
   localparam int unsigned IW    = $clog2(MAX_SEGMENTS + 1);
   localparam int unsigned NW    = (IW > CSR_W) ? IW : CSR_W;
   localparam int unsigned IXW   = (AW > SEG_INDEX_W) ? AW : SEG_INDEX_W;
   localparam int unsigned DW    = SAMPLE_W + 1;
   localparam int unsigned PW    = DW + SLOPE_W;
   localparam int unsigned SW    = PW + 1;

   localparam logic signed [SW-1:0] SUM_HI = SW'(SAT_HI);
   localparam logic signed [SW-1:0] SUM_LO = SW'(SAT_LO);

   // One search slot: write beats and evaluate beats share it
   typedef struct packed {
      logic                        valid;
      logic                        is_wr;
      logic                        wr_ok;
      logic [AW-1:0]               wr_addr;
      logic [BASE_KEEP_W-1:0]      base;
      logic [SEL_W-1:0]            sel;
      logic signed [LEVEL_W-1:0]   level;
      logic signed [SLOPE_W-1:0]   slope;
      logic signed [SAMPLE_W-1:0]  x;
      logic [IW-1:0]               lo;
      logic [IW-1:0]               hi;
      logic                        below;
      logic signed [LEVEL_W-1:0]   lvl0;
   } slot_type;

   typedef struct packed {
      logic [BASE_KEEP_W-1:0]      base;
      logic [SEL_W-1:0]            sel;
      logic signed [LEVEL_W-1:0]   level;
      logic signed [SLOPE_W-1:0]   slope;
   } entry_type;

   typedef struct packed {
      logic                        valid;
      logic signed [SAMPLE_W-1:0]  x;
      logic                        below;
      logic signed [LEVEL_W-1:0]   lvl0;
   } lookup_type;

   typedef struct packed {
      logic                        valid;
      logic signed [DW-1:0]        diff;
      logic signed [SLOPE_W-1:0]   slope;
      logic [SEL_W-1:0]            sel;
      logic signed [LEVEL_W-1:0]   level;
      logic                        below;
      logic signed [LEVEL_W-1:0]   lvl0;
   } diff_type;

   typedef struct packed {
      logic                        valid;
      logic signed [PW-1:0]        prod;
      logic [SEL_W-1:0]            sel;
      logic signed [LEVEL_W-1:0]   level;
      logic                        below;
      logic signed [LEVEL_W-1:0]   lvl0;
   } prod_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } out_type;

   function automatic logic [IW-1:0] mid_point(input logic [IW-1:0] a, input logic [IW-1:0] b);
      logic [IW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[IW:1];
   endfunction

   logic [CSR_W-1:0]       csr_count_ff;
   logic [NW-1:0]          count_ext;
   logic [IW-1:0]          n_cur;
   logic                   advance;

   logic [BASE_KEEP_W-1:0] seg0_base_ff;
   logic signed [LEVEL_W-1:0] seg0_level_ff;

   slot_type               slot_ff [STEPS+1];
   slot_type               slot_in [STEPS+1];
   logic [IW-1:0]          eff_lo  [STEPS+1];
   logic [IW-1:0]          eff_hi  [STEPS+1];
   logic [IW-1:0]          rd_mid  [STEPS];
   logic [BASE_KEEP_W-1:0] rd_base_ff [STEPS];
   entry_type              rd_entry_ff;

   lookup_type             lk_ff, lk_in;
   diff_type               ar1_ff, ar1_in;
   prod_type               ar2_ff, ar2_in;
   out_type                out_ff, out_in;

   logic [IXW:0]           idx_ext;
   logic signed [PW-1:0]   shifted;
   logic signed [SW-1:0]   sum;

   // ------------------------------------------------------------------
   // Configuration: segment count, clamped to the table depth
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= '0;
      end else if (csr_wr_en) begin
         csr_count_ff <= csr_wr_data;
      end
   end

   assign count_ext = NW'(csr_count_ff);
   assign n_cur = (count_ext > NW'(MAX_SEGMENTS)) ? IW'(MAX_SEGMENTS) : IW'(count_ext);

   // The whole pipeline moves together; it holds only while a response beat waits.
   assign advance   = !out_ff.valid || !rsp_stall;
   assign req_stall = !advance;

   // ------------------------------------------------------------------
   // Entry slot: decode the request beat. Evaluations with no segments
   // in use are dropped here.
   // ------------------------------------------------------------------
   assign idx_ext = (IXW + 1)'(req_data.seg_index);

   always_comb begin
      slot_in[0]         = '0;
      slot_in[0].valid   = req_valid &&
                           ((req_data.action == ACTION_WRITE) || (n_cur != '0));
      slot_in[0].is_wr   = (req_data.action == ACTION_WRITE);
      slot_in[0].wr_ok   = idx_ext < (IXW + 1)'(MAX_SEGMENTS);
      slot_in[0].wr_addr = idx_ext[AW-1:0];
      slot_in[0].base    = req_data.seg_base[BASE_W-1:BASE_DROP_W];
      slot_in[0].sel     = req_data.seg_shift_select;
      slot_in[0].level   = req_data.seg_level;
      slot_in[0].slope   = req_data.seg_slope;
      slot_in[0].x       = req_data.sample;
      slot_in[0].lo      = '0;
      slot_in[0].hi      = n_cur;
   end

   // Segment 0 is held in flops for the below-first-base check in slot 0.
   always_ff @(posedge clock) begin
      if (advance && slot_ff[0].valid && slot_ff[0].is_wr && slot_ff[0].wr_ok &&
          (slot_ff[0].wr_addr == '0)) begin
         seg0_base_ff  <= slot_ff[0].base;
         seg0_level_ff <= slot_ff[0].level;
      end
   end

   assign eff_lo[0] = slot_ff[0].lo;
   assign eff_hi[0] = slot_ff[0].hi;

   // ------------------------------------------------------------------
   // Search slots. Slot j settles the decision on the base read from
   // copy j-1, then addresses copy j at the new midpoint. Write beats
   // update copy j while passing slot j, so every evaluation sees the
   // table exactly as its own order in the stream leaves it.
   // ------------------------------------------------------------------
   for (genvar j = 1; j <= STEPS; j++) begin : g_step
      logic          active;
      logic          gt;
      logic [IW-1:0] k;

      always_comb begin
         active = (IW + 1)'(slot_ff[j].hi) > ((IW + 1)'(slot_ff[j].lo) + (IW + 1)'(1));
         k      = mid_point(slot_ff[j].lo, slot_ff[j].hi);
         gt     = $signed({rd_base_ff[j-1], BASE_DROP_W'(0)}) > slot_ff[j].x;
         eff_lo[j] = (active && !gt) ? k : slot_ff[j].lo;
         eff_hi[j] = (active && gt)  ? k : slot_ff[j].hi;
      end

      always_comb begin
         slot_in[j]    = slot_ff[j-1];
         slot_in[j].lo = eff_lo[j-1];
         slot_in[j].hi = eff_hi[j-1];
         if (j == 1) begin
            slot_in[j].below = slot_ff[0].x <= $signed({seg0_base_ff, BASE_DROP_W'(0)});
            slot_in[j].lvl0  = seg0_level_ff;
         end
      end
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_base_copy
      logic [BASE_KEEP_W-1:0] base_mem [MAX_SEGMENTS];

      assign rd_mid[j] = mid_point(eff_lo[j], eff_hi[j]);

      always_ff @(posedge clock) begin
         if (advance && slot_ff[j].valid && slot_ff[j].is_wr && slot_ff[j].wr_ok) begin
            base_mem[slot_ff[j].wr_addr] <= slot_ff[j].base;
         end
         if (advance) begin
            rd_base_ff[j] <= base_mem[rd_mid[j][AW-1:0]];
         end
      end
   end

   // Full entries live in the last copy, read at the settled lower bound.
   entry_type entry_mem [MAX_SEGMENTS];

   always_ff @(posedge clock) begin
      if (advance && slot_ff[STEPS].valid && slot_ff[STEPS].is_wr && slot_ff[STEPS].wr_ok) begin
         entry_mem[slot_ff[STEPS].wr_addr] <= '{base:  slot_ff[STEPS].base,
                                               sel:   slot_ff[STEPS].sel,
                                               level: slot_ff[STEPS].level,
                                               slope: slot_ff[STEPS].slope};
      end
      if (advance) begin
         rd_entry_ff <= entry_mem[eff_lo[STEPS][AW-1:0]];
      end
   end

   for (genvar j = 0; j <= STEPS; j++) begin : g_slot_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            slot_ff[j].valid <= 1'b0;
         end else if (advance) begin
            slot_ff[j] <= slot_in[j];
         end
      end
   end

   // ------------------------------------------------------------------
   // Arithmetic: difference, product, then shift, add and clamp, or the
   // level of segment 0 at or below its base. Write beats drop out here.
   // ------------------------------------------------------------------
   always_comb begin
      lk_in.valid = slot_ff[STEPS].valid && !slot_ff[STEPS].is_wr;
      lk_in.x     = slot_ff[STEPS].x;
      lk_in.below = slot_ff[STEPS].below;
      lk_in.lvl0  = slot_ff[STEPS].lvl0;
   end

   always_comb begin
      ar1_in.valid = lk_ff.valid;
      ar1_in.diff  = DW'(lk_ff.x) - DW'($signed({rd_entry_ff.base, BASE_DROP_W'(0)}));
      ar1_in.slope = rd_entry_ff.slope;
      ar1_in.sel   = rd_entry_ff.sel;
      ar1_in.level = rd_entry_ff.level;
      ar1_in.below = lk_ff.below;
      ar1_in.lvl0  = lk_ff.lvl0;
   end

   always_comb begin
      ar2_in.valid = ar1_ff.valid;
      ar2_in.prod  = PW'(ar1_ff.diff) * PW'(ar1_ff.slope);
      ar2_in.sel   = ar1_ff.sel;
      ar2_in.level = ar1_ff.level;
      ar2_in.below = ar1_ff.below;
      ar2_in.lvl0  = ar1_ff.lvl0;
   end

   always_comb begin
      case (ar2_ff.sel)
         2'd0:    shifted = ar2_ff.prod >>> 8;
         2'd1:    shifted = ar2_ff.prod >>> 16;
         2'd2:    shifted = ar2_ff.prod >>> 24;
         default: shifted = ar2_ff.prod >>> 32;
      endcase
      sum = SW'(shifted) + SW'(ar2_ff.level);

      out_in.valid = ar2_ff.valid;
      if (ar2_ff.below) begin
         out_in.data.out_value = ar2_ff.lvl0;
         out_in.data.saturated = 1'b0;
      end else if (sum > SUM_HI) begin
         out_in.data.out_value = OUT_W'(SAT_HI);
         out_in.data.saturated = 1'b1;
      end else if (sum < SUM_LO) begin
         out_in.data.out_value = OUT_W'(SAT_LO);
         out_in.data.saturated = 1'b1;
      end else begin
         out_in.data.out_value = sum[OUT_W-1:0];
         out_in.data.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lk_ff.valid  <= 1'b0;
         ar1_ff.valid <= 1'b0;
         ar2_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         lk_ff  <= lk_in;
         ar1_ff <= ar1_in;
         ar2_ff <= ar2_in;
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_ff.valid;
   assign rsp_data  = out_ff.data;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while response beat is held");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
      ((rsp_data.out_value == OUT_W'(SAT_HI)) || (rsp_data.out_value == OUT_W'(SAT_LO))))
      else $error("saturated flag without a clamped value");

   a_search_done: assert property (@(posedge clock) disable iff (reset)
      (slot_ff[STEPS].valid && !slot_ff[STEPS].is_wr) |->
      ((IW + 1)'(eff_hi[STEPS]) == ((IW + 1)'(eff_lo[STEPS]) + (IW + 1)'(1))))
      else $error("search did not converge in the last slot");

   a_bounds: assert property (@(posedge clock) disable iff (reset)
      (slot_ff[1].valid && !slot_ff[1].is_wr) |->
      ((slot_ff[1].hi != '0) && (slot_ff[1].hi <= IW'(MAX_SEGMENTS))))
      else $error("search bounds out of range");

endmodule
